FILE: src/awlru_pkg.sv
// Shared constants, transaction types and line-cell chain types for the write cache.
package awlru_pkg;

  localparam int LINES       = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int MEM_BLOCKS  = 256;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 32;
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int BLK_W  = $clog2(MEM_BLOCKS);
  localparam int IDX_W  = $clog2(LINES);
  localparam int AGE_W  = IDX_W;

  typedef struct packed {
    logic [ADDR_W-1:0]        byte_address;
    logic signed [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [IDX_W-1:0]         line_used;
    logic                     mem_write;
    logic                     mem_is_eviction;
    logic [BLK_W-1:0]         mem_block;
    logic signed [DATA_W-1:0] mem_data;
  } out_item_t;

  // Lookup results accumulated from cell to cell
  typedef struct packed {
    logic                     hit_found;
    logic [IDX_W-1:0]         hit_idx;
    logic [AGE_W-1:0]         hit_age;
    logic                     inv_found;
    logic [IDX_W-1:0]         inv_idx;
    logic [AGE_W-1:0]         vic_age;
    logic [IDX_W-1:0]         vic_idx;
    logic [BLK_W-1:0]         vic_block;
    logic signed [DATA_W-1:0] vic_word;
    logic                     vic_dirty;
  } scan_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         sel;
    logic [AGE_W:0]           old_age;
    logic [BLK_W-1:0]         blk;
    logic signed [DATA_W-1:0] word;
    logic                     wb_mode;
  } upd_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } cell_stat_t;

  function automatic logic [BLK_W-1:0] block_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] shifted;
    shifted = addr >> OFF_W;
    return BLK_W'(shifted);
  endfunction

endpackage

FILE: src/awlru_cell.sv
// One cache line: tag, data, dirty mark and age, plus its step of the lookup chain.
module awlru_cell import awlru_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  upd_t             upd,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  output cell_stat_t       stat
);

  logic                     valid_r, valid_nxt;
  logic [BLK_W-1:0]         block_r, block_nxt;
  logic                     dirty_r, dirty_nxt;
  logic signed [DATA_W-1:0] word_r, word_nxt;
  logic [AGE_W-1:0]         age_r, age_nxt;
  logic                     hit_here;

  assign hit_here   = valid_r && (block_r == upd.blk);
  assign stat.valid = valid_r;
  assign stat.hit   = hit_here;

  always_comb begin
    scan_out = scan_in;
    if (hit_here && !scan_in.hit_found) begin
      scan_out.hit_found = 1'b1;
      scan_out.hit_idx   = cell_idx;
      scan_out.hit_age   = age_r;
    end
    if (!valid_r && !scan_in.inv_found) begin
      scan_out.inv_found = 1'b1;
      scan_out.inv_idx   = cell_idx;
    end
    // oldest line wins, lowest index on ties; line 0 seeds the search
    if ((cell_idx == IDX_W'(0)) || (age_r > scan_in.vic_age)) begin
      scan_out.vic_age   = age_r;
      scan_out.vic_idx   = cell_idx;
      scan_out.vic_block = block_r;
      scan_out.vic_word  = word_r;
      scan_out.vic_dirty = dirty_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    block_nxt = block_r;
    dirty_nxt = dirty_r;
    word_nxt  = word_r;
    age_nxt   = age_r;
    if (upd.we) begin
      if (upd.sel == cell_idx) begin
        valid_nxt = 1'b1;
        block_nxt = upd.blk;
        dirty_nxt = upd.wb_mode;
        word_nxt  = upd.word;
        age_nxt   = '0;
      end else if (valid_r && ({1'b0, age_r} < upd.old_age)) begin
        age_nxt = AGE_W'(age_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      block_r <= '0;
      dirty_r <= 1'b0;
      word_r  <= '0;
      age_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      block_r <= block_nxt;
      dirty_r <= dirty_nxt;
      word_r  <= word_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

FILE: src/assoc_write_cache_lru_core.sv
// A transaction is held in the input register, then in the result register; while the result
// side stalls it waits in the input register, and the result is shown with out_valid high.
// Throughput: one transaction per cycle while the result side keeps up; each transaction
// is looked up through the chain of line cells and written as it leaves the input register.
// Reset (synchronous, rst_n low) clears all lines, dirty marks, ages and selects
// write-through mode; the block takes transactions in the first cycle after reset.
module assoc_write_cache_lru_core import awlru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic       mode_r;
  logic       in_full_r, in_full_nxt;
  in_item_t   in_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       fire;
  logic       in_take;

  scan_t            scan [0:LINES];
  cell_stat_t       stat [0:LINES-1];
  logic [LINES-1:0] valid_vec;
  logic [LINES-1:0] hit_vec;
  upd_t             upd;
  scan_t            res;
  logic             evict;

  assign fire    = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !fire;
  assign in_take = in_valid && !in_stall;

  assign scan[0] = '0;
  assign res     = scan[LINES];

  for (genvar g = 0; g < LINES; g++) begin : g_line
    awlru_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .upd      (upd),
      .scan_in  (scan[g]),
      .scan_out (scan[g+1]),
      .stat     (stat[g])
    );
    assign valid_vec[g] = stat[g].valid;
    assign hit_vec[g]   = stat[g].hit;
  end

  always_comb begin
    upd.we      = fire;
    upd.blk     = block_of(in_r.byte_address);
    upd.word    = in_r.write_value;
    upd.wb_mode = mode_r;
    if (res.hit_found) begin
      upd.sel     = res.hit_idx;
      upd.old_age = {1'b0, res.hit_age};
    end else if (res.inv_found) begin
      upd.sel     = res.inv_idx;
      upd.old_age = (AGE_W+1)'(LINES);
    end else begin
      upd.sel     = res.vic_idx;
      upd.old_age = {1'b0, res.vic_age};
    end
  end

  assign evict = !res.hit_found && !res.inv_found && mode_r && res.vic_dirty;

  always_comb begin
    out_nxt.hit       = res.hit_found;
    out_nxt.line_used = upd.sel;
    if (!mode_r) begin
      out_nxt.mem_write       = 1'b1;
      out_nxt.mem_is_eviction = 1'b0;
      out_nxt.mem_block       = upd.blk;
      out_nxt.mem_data        = in_r.write_value;
    end else if (evict) begin
      out_nxt.mem_write       = 1'b1;
      out_nxt.mem_is_eviction = 1'b1;
      out_nxt.mem_block       = res.vic_block;
      out_nxt.mem_data        = res.vic_word;
    end else begin
      out_nxt.mem_write       = 1'b0;
      out_nxt.mem_is_eviction = 1'b0;
      out_nxt.mem_block       = '0;
      out_nxt.mem_data        = '0;
    end
  end

  always_comb begin
    in_full_nxt = in_full_r;
    if (fire) begin
      in_full_nxt = 1'b0;
    end
    if (in_take) begin
      in_full_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // tags of valid lines stay distinct
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one line matches the block");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed transaction did not produce a result");

  a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> valid_vec[$past(upd.sel)])
    else $error("written line is not valid afterwards");
`endif

endmodule

FILE: tb/assoc_write_cache_lru_core_tb.sv
// Self-checking testbench for the fully associative LRU write cache core.
module assoc_write_cache_lru_core_tb;
  import awlru_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  // Tracks tags, ages, dirty marks and data words; predicts one result per write
  class cache_tracker;
    logic              tag_valid [LINES];
    logic [BLK_W-1:0]  tag_block [LINES];
    logic              dirty_bit [LINES];
    logic [DATA_W-1:0] data_word [LINES];
    int                lru_age   [LINES];
    bit                wb_enabled;
    out_item_t         due_results[$];
    int                errors;
    int                writes;
    int                hits;
    int                evictions;
    int                wt_writes;

    function new();
      foreach (tag_valid[i]) begin
        tag_valid[i] = 1'b0;
        tag_block[i] = '0;
        dirty_bit[i] = 1'b0;
        data_word[i] = '0;
        lru_age[i]   = 0;
      end
      wb_enabled = 1'b0;
    endfunction

    function void note_write(in_item_t w);
      logic [BLK_W-1:0] blk;
      int               sel;
      int               old_age;
      int               oldest;
      out_item_t        r;
      blk     = BLK_W'(w.byte_address / BLOCK_BYTES);
      sel     = -1;
      old_age = LINES;
      r       = '0;
      for (int i = 0; i < LINES; i++)
        if (sel < 0 && tag_valid[i] && tag_block[i] == blk) sel = i;
      if (sel >= 0) begin
        r.hit   = 1'b1;
        old_age = lru_age[sel];
      end else begin
        for (int i = 0; i < LINES; i++)
          if (sel < 0 && !tag_valid[i]) sel = i;
        if (sel < 0) begin
          // all lines busy: replace the oldest, lowest index on a tie
          oldest = 0;
          sel    = 0;
          for (int i = 0; i < LINES; i++)
            if (lru_age[i] > oldest) begin
              oldest = lru_age[i];
              sel    = i;
            end
          old_age = lru_age[sel];
          if (wb_enabled && dirty_bit[sel]) begin
            r.mem_write       = 1'b1;
            r.mem_is_eviction = 1'b1;
            r.mem_block       = tag_block[sel];
            r.mem_data        = data_word[sel];
            evictions++;
          end
        end
      end
      for (int i = 0; i < LINES; i++)
        if (i != sel && tag_valid[i] && lru_age[i] < old_age) lru_age[i]++;
      lru_age[sel]   = 0;
      tag_valid[sel] = 1'b1;
      tag_block[sel] = blk;
      data_word[sel] = w.write_value;
      if (wb_enabled) begin
        dirty_bit[sel] = 1'b1;
      end else begin
        // write-through drops any stale dirty data of the victim
        dirty_bit[sel]    = 1'b0;
        r.mem_write       = 1'b1;
        r.mem_is_eviction = 1'b0;
        r.mem_block       = blk;
        r.mem_data        = w.write_value;
        wt_writes++;
      end
      r.line_used = IDX_W'(sel);
      if (r.hit) hits++;
      writes++;
      due_results.push_back(r);
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction outstanding, expected none, actual %p",
                 $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("line_used", 32'(want.line_used), 32'(got.line_used));
      compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
      compare_field("mem_is_eviction", 32'(want.mem_is_eviction),
                    32'(got.mem_is_eviction));
      compare_field("mem_block", 32'(want.mem_block), 32'(got.mem_block));
      compare_field("mem_data", want.mem_data, got.mem_data);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           cycles = 0;
  cache_tracker tracker = new();

  assoc_write_cache_lru_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_result(out_data);
      if (in_valid && !in_stall) tracker.note_write(in_data);
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Idle decision is made per cycle so the idle share matches tx_idle_pct
  task automatic send_write(input in_item_t w);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender off until every transaction has produced its result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.wb_enabled = m;
  endtask

  task automatic run_segment(input int count, input bit mode, input int tx_pct,
                             input int rx_pct, input bit midway_pause);
    logic [BLK_W-1:0] hot [8];
    int               hot_n;
    in_item_t         w;
    settle();
    write_mode(mode);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    hot_n = 3;
    for (int n = 0; n < count; n++) begin
      // small, shifting working set so hits and evictions both stay frequent
      if (n % 50 == 0) begin
        hot_n = $urandom_range(8, 3);
        foreach (hot[k]) hot[k] = BLK_W'($urandom);
      end
      if (midway_pause && n == count / 2) settle();
      if ($urandom_range(99) < 80)
        w.byte_address = {hot[$urandom_range(hot_n - 1)], OFF_W'($urandom)};
      else
        w.byte_address = ADDR_W'($urandom);
      case ($urandom_range(11))
        0:       w.write_value = '0;
        1:       w.write_value = '1;
        2:       w.write_value = {1'b0, {(DATA_W - 1){1'b1}}};
        3:       w.write_value = {1'b1, {(DATA_W - 1){1'b0}}};
        default: w.write_value = $urandom;
      endcase
      send_write(w);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: write-through fill, hit, full-cache replacement
    write_mode(1'b0);
    send_write(in_item_t'{12'h000, 32'h0000_0000});
    send_write(in_item_t'{12'hFFF, 32'h7FFF_FFFF});
    send_write(in_item_t'{12'h00F, 32'h8000_0000});
    send_write(in_item_t'{12'h010, 32'hFFFF_FFFF});
    send_write(in_item_t'{12'h020, 32'h5555_5555});
    send_write(in_item_t'{12'h030, 32'hAAAA_AAAA});
    // Write-back: clean victims first, then dirty evictions
    settle();
    write_mode(1'b1);
    send_write(in_item_t'{12'h030, 32'h0000_0001});
    send_write(in_item_t'{12'h040, 32'h0000_0002});
    send_write(in_item_t'{12'h050, 32'h0000_0003});
    send_write(in_item_t'{12'h060, 32'h0000_0004});
    send_write(in_item_t'{12'h070, 32'h0000_0005});
    send_write(in_item_t'{12'h080, 32'h0000_0006});
    send_write(in_item_t'{12'h08C, 32'h0000_0007});
    send_write(in_item_t'{12'h0A0, 32'h0000_0008});
    // Back to write-through with dirty lines left behind
    settle();
    write_mode(1'b0);
    send_write(in_item_t'{12'h0B0, 32'h0000_0009});
    send_write(in_item_t'{12'h0A0, 32'h0000_000A});
    send_write(in_item_t'{12'h0C0, 32'h0000_000B});

    run_segment(300, 1'b1, 11, 69, 1'b0);
    run_segment(300, 1'b0, 11, 69, 1'b0);
    run_segment(300, 1'b1, 69, 11, 1'b1);
    run_segment(300, 1'b0, 69, 11, 1'b0);
    run_segment(300, 1'b1, 0, 0, 1'b0);
    run_segment(300, 1'b0, 0, 0, 1'b0);
    settle();

    $display("Checked %0d writes: %0d hits, %0d dirty evictions, %0d write-through writes.",
             tracker.writes, tracker.hits, tracker.evictions, tracker.wt_writes);
    $display("Both write modes, mode switches over dirty lines, and mixed stall patterns.");
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
